>>> rtl/nddi_pkg.sv
// Shared types, constants and helpers for the Newton divided-difference interpolator.
// No dependencies.
package nddi_pkg;

    localparam int MAX_POINTS = 16;
    localparam int FRAC_BITS  = 16;
    localparam int DATA_W     = 32;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int INDEX_W    = 4;
    localparam int DEN_W      = DATA_W + 1;
    localparam int NUM_W      = DEN_W + FRAC_BITS;
    localparam int HALF_W     = DATA_W / 2;
    localparam int PROD_W     = DEN_W + DATA_W;
    localparam int MAG_W      = PROD_W - FRAC_BITS;
    localparam int SUM_W      = NUM_W + 3;
    localparam int PP_W       = DEN_W + HALF_W;

    localparam logic [DATA_W-1:0] Q_ONE = DATA_W'(1) << FRAC_BITS;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_SAT  = 2'd1;
    localparam logic [1:0] ST_DUP  = 2'd2;
    localparam logic [1:0] ST_NRDY = 2'd3;

    localparam logic KIND_COEF = 1'b0;
    localparam logic KIND_EVAL = 1'b1;
    localparam logic FUNC_LOAD = 1'b0;

    typedef struct packed {
        logic                     func;
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic                     last;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic [INDEX_W-1:0]       index;
        logic                     kind;
        logic [1:0]               status;
        logic                     end_of_run;
    } out_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] val;
        logic                     hit;
    } sat_t;

    typedef enum logic [4:0] {
        S_IDLE, S_B_RD, S_B_CALC, S_B_DIV, S_EM_RD, S_EM_OUT,
        S_EV_RD0, S_EV_INIT, S_EV_RD, S_EV_LD, S_EV_M1A, S_EV_M1B,
        S_EV_P, S_EV_M2A, S_EV_M2B, S_EV_ACC, S_EV_OUT
    } state_t;

    // clamp a wide signed value to 32 bits
    function automatic sat_t sat_fn(input logic signed [SUM_W-1:0] v);
        sat_t r;
        logic ok;
        ok    = (&v[SUM_W-1:DATA_W-1]) || !(|v[SUM_W-1:DATA_W-1]);
        r.hit = !ok;
        if (ok)
            r.val = v[DATA_W-1:0];
        else if (v[SUM_W-1])
            r.val = {1'b1, {(DATA_W-1){1'b0}}};
        else
            r.val = {1'b0, {(DATA_W-1){1'b1}}};
        return r;
    endfunction

endpackage

>>> rtl/nddi_if.sv
// Valid/ready channel interfaces for the interpolator input and result streams.
// Depends on nddi_pkg.
interface nddi_in_if;
    logic              valid;
    logic              ready;
    nddi_pkg::in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface nddi_out_if;
    logic               valid;
    logic               ready;
    nddi_pkg::out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/nddi_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on nddi_pkg.
module nddi_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [nddi_pkg::NUM_W-1:0]    numer,
    input  logic [nddi_pkg::DEN_W-1:0]    denom,
    output logic                          done,
    output logic [nddi_pkg::NUM_W-1:0]    quot
);

    localparam int CW = $clog2(nddi_pkg::NUM_W + 1);

    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [CW-1:0]              cnt_reg, cnt_next;
    logic [nddi_pkg::DEN_W-1:0] rem_reg, rem_next;
    logic [nddi_pkg::DEN_W-1:0] den_reg, den_next;
    logic [nddi_pkg::NUM_W-1:0] num_reg, num_next;
    logic [nddi_pkg::NUM_W-1:0] q_reg, q_next;
    logic [nddi_pkg::DEN_W:0]   trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        num_next  = num_reg;
        q_next    = q_reg;
        trial     = {rem_reg, num_reg[nddi_pkg::NUM_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(nddi_pkg::NUM_W);
            rem_next  = '0;
            den_next  = denom;
            num_next  = numer;
            q_next    = '0;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = nddi_pkg::DEN_W'(trial - {1'b0, den_reg});
                q_next   = {q_reg[nddi_pkg::NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[nddi_pkg::DEN_W-1:0];
                q_next   = {q_reg[nddi_pkg::NUM_W-2:0], 1'b0};
            end
            num_next = {num_reg[nddi_pkg::NUM_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        num_reg <= num_next;
        q_reg   <= q_next;
    end

    assign done = done_reg;
    assign quot = q_reg;

`ifndef SYNTHESIS
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a running division");
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider restarted while busy");
    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !start |=> rem_reg < den_reg || den_reg == '0)
        else $error("divider remainder out of range");
`endif

endmodule

>>> rtl/newton_divided_difference_interp.sv
// Newton divided-difference interpolator: node load, in-place coefficient build
// in block RAM, coefficient emission and Newton-form evaluation.
// The last node of n builds n*(n-1)/2 table entries (a division each, none if duplicate),
// then emits the coefficients; a query takes a product update and an accumulate per term.
// The 49-step divider sets build time; the 33x16 multiplier query time.
// Reset (async, active low) clears node count, coefficient-valid and all control state.
module newton_divided_difference_interp (
    input  logic           clk,
    input  logic           rst_n,
    nddi_in_if.sink        din,
    nddi_out_if.source     dout
);

    localparam int IW = nddi_pkg::IDX_W;
    localparam int CW = nddi_pkg::CNT_W;
    localparam int DW = nddi_pkg::DATA_W;

    // Node x memory and the difference table (value plus 2-bit status per entry).
    // After a build the difference table holds the coefficients.
    logic [DW-1:0]   node_mem [nddi_pkg::MAX_POINTS];
    logic [DW+1:0]   work_mem [nddi_pkg::MAX_POINTS];

    logic            rd_en;
    logic [IW-1:0]   na0, na1, wa0, wa1, waddr;
    logic            node_we, work_we;
    logic [DW-1:0]   node_wdata;
    logic [DW+1:0]   work_wdata;
    logic [DW-1:0]   n0_reg, n1_reg;
    logic [DW+1:0]   w0_reg, w1_reg;

    always_ff @(posedge clk)
    begin
        if (node_we)
            node_mem[waddr] <= node_wdata;
        if (work_we)
            work_mem[waddr] <= work_wdata;
        if (rd_en)
        begin
            n0_reg <= node_mem[na0];
            n1_reg <= node_mem[na1];
            w0_reg <= work_mem[wa0];
            w1_reg <= work_mem[wa1];
        end
    end

    nddi_pkg::state_t          state_reg, state_next;
    logic [CW-1:0]             cnt_reg, cnt_next;
    logic                      cvalid_reg, cvalid_next;
    logic [CW-1:0]             i_reg, i_next;
    logic [CW-1:0]             j_reg, j_next;
    logic signed [DW-1:0]      x_reg, x_next;
    logic signed [DW-1:0]      acc_reg, acc_next;
    logic signed [DW-1:0]      prod_reg, prod_next;
    logic [1:0]                st_reg, st_next;
    logic [1:0]                bst_reg, bst_next;
    logic                      dneg_reg, dneg_next;
    logic [nddi_pkg::DEN_W-1:0] ma_reg, ma_next;
    logic [DW-1:0]             mb_reg, mb_next;
    logic                      mneg_reg, mneg_next;
    logic [nddi_pkg::PROD_W-1:0] p_reg, p_next;
    logic                      out_valid_reg, out_valid_next;
    nddi_pkg::out_item_t       out_data_reg, out_data_next;

    // divider hookup
    logic                        div_start, div_done;
    logic [nddi_pkg::NUM_W-1:0]  div_num, div_quot;
    logic [nddi_pkg::DEN_W-1:0]  div_den;

    nddi_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (div_num),
        .denom (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    // datapath helpers
    logic                            out_free;
    logic signed [DW:0]              dnode, dwork, dx;
    logic [nddi_pkg::DEN_W-1:0]      dnode_mag, dwork_mag, dx_mag;
    logic [nddi_pkg::PP_W-1:0]       pp;
    logic [nddi_pkg::MAG_W-1:0]      mag;
    logic signed [nddi_pkg::SUM_W-1:0] mres, qres, asum;
    nddi_pkg::sat_t                  s_mul, s_div, s_sum;
    logic [1:0]                      base_st;
    logic [CW-1:0]                   cnt_eff, cnt_new;
    logic [DW-1:0]                   w0_mag, prod_mag;
    logic                            build_next_j;

    assign out_free = !out_valid_reg || dout.ready;
    assign din.ready = (state_reg == nddi_pkg::S_IDLE);
    assign dout.valid = out_valid_reg;
    assign dout.data = out_data_reg;

    always_comb
    begin
        dnode     = {n0_reg[DW-1], n0_reg} - {n1_reg[DW-1], n1_reg};
        dwork     = {w0_reg[DW-1], w0_reg[DW-1:0]} - {w1_reg[DW-1], w1_reg[DW-1:0]};
        dx        = {x_reg[DW-1], x_reg} - {n0_reg[DW-1], n0_reg};
        dnode_mag = dnode[DW] ? nddi_pkg::DEN_W'(-dnode) : nddi_pkg::DEN_W'(dnode);
        dwork_mag = dwork[DW] ? nddi_pkg::DEN_W'(-dwork) : nddi_pkg::DEN_W'(dwork);
        dx_mag    = dx[DW] ? nddi_pkg::DEN_W'(-dx) : nddi_pkg::DEN_W'(dx);
        w0_mag    = w0_reg[DW-1] ? DW'(-w0_reg[DW-1:0]) : w0_reg[DW-1:0];
        prod_mag  = prod_reg[DW-1] ? DW'(-prod_reg) : DW'(prod_reg);
        base_st   = (w0_reg[DW+1:DW] > w1_reg[DW+1:DW]) ? w0_reg[DW+1:DW] : w1_reg[DW+1:DW];
        // one 33x16 multiplier, low half then high half of mb
        if (state_reg == nddi_pkg::S_EV_M1B || state_reg == nddi_pkg::S_EV_M2B)
            pp = nddi_pkg::PP_W'(ma_reg) * nddi_pkg::PP_W'(mb_reg[DW-1:nddi_pkg::HALF_W]);
        else
            pp = nddi_pkg::PP_W'(ma_reg) * nddi_pkg::PP_W'(mb_reg[nddi_pkg::HALF_W-1:0]);
        mag   = p_reg[nddi_pkg::PROD_W-1:nddi_pkg::FRAC_BITS];
        mres  = mneg_reg ? -$signed(nddi_pkg::SUM_W'(mag)) : $signed(nddi_pkg::SUM_W'(mag));
        qres  = dneg_reg ? -$signed(nddi_pkg::SUM_W'(div_quot))
                         : $signed(nddi_pkg::SUM_W'(div_quot));
        asum  = nddi_pkg::SUM_W'(acc_reg) + mres;
        s_mul = nddi_pkg::sat_fn(mres);
        s_div = nddi_pkg::sat_fn(qres);
        s_sum = nddi_pkg::sat_fn(asum);
        cnt_eff = cvalid_reg ? '0 : cnt_reg;
        cnt_new = (cnt_eff < CW'(nddi_pkg::MAX_POINTS)) ? cnt_eff + 1'b1 : cnt_eff;
        build_next_j = !(i_reg > j_reg);
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        cvalid_next    = cvalid_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        x_next         = x_reg;
        acc_next       = acc_reg;
        prod_next      = prod_reg;
        st_next        = st_reg;
        bst_next       = bst_reg;
        dneg_next      = dneg_reg;
        ma_next        = ma_reg;
        mb_next        = mb_reg;
        mneg_next      = mneg_reg;
        p_next         = p_reg;
        out_valid_next = out_valid_reg && !dout.ready;
        out_data_next  = out_data_reg;
        rd_en          = 1'b0;
        na0            = '0;
        na1            = '0;
        wa0            = '0;
        wa1            = '0;
        waddr          = i_reg[IW-1:0];
        node_we        = 1'b0;
        work_we        = 1'b0;
        node_wdata     = din.data.x;
        work_wdata     = {nddi_pkg::ST_OK, din.data.y};
        div_start      = 1'b0;
        div_num        = {dwork_mag, {nddi_pkg::FRAC_BITS{1'b0}}};
        div_den        = dnode_mag;

        unique case (state_reg) inside
            nddi_pkg::S_IDLE:
            begin
                if (din.valid)
                begin
                    x_next = din.data.x;
                    if (din.data.func != nddi_pkg::FUNC_LOAD)
                    begin
                        if (!cvalid_reg || cnt_reg == '0)
                        begin
                            acc_next   = '0;
                            st_next    = nddi_pkg::ST_NRDY;
                            state_next = nddi_pkg::S_EV_OUT;
                        end
                        else
                            state_next = nddi_pkg::S_EV_RD0;
                    end
                    else
                    begin
                        cvalid_next = 1'b0;
                        cnt_next    = cnt_new;
                        waddr       = cnt_eff[IW-1:0];
                        if (cnt_eff < CW'(nddi_pkg::MAX_POINTS))
                        begin
                            node_we = 1'b1;
                            work_we = 1'b1;
                        end
                        if (din.data.last)
                        begin
                            if (cnt_new > CW'(1))
                            begin
                                j_next     = CW'(1);
                                i_next     = cnt_new - 1'b1;
                                state_next = nddi_pkg::S_B_RD;
                            end
                            else
                            begin
                                i_next      = '0;
                                cvalid_next = 1'b1;
                                state_next  = nddi_pkg::S_EM_RD;
                            end
                        end
                    end
                end
            end

            // difference table: entry i from entries i and i-1, nodes i and i-j
            nddi_pkg::S_B_RD:
            begin
                rd_en      = 1'b1;
                na0        = i_reg[IW-1:0];
                na1        = IW'(i_reg - j_reg);
                wa0        = i_reg[IW-1:0];
                wa1        = IW'(i_reg - 1'b1);
                state_next = nddi_pkg::S_B_CALC;
            end

            nddi_pkg::S_B_CALC:
            begin
                if (dnode == '0)
                begin
                    // duplicate node x
                    work_we    = 1'b1;
                    work_wdata = {nddi_pkg::ST_DUP, {DW{1'b0}}};
                    state_next = nddi_pkg::S_B_RD;
                    if (build_next_j)
                    begin
                        j_next = j_reg + 1'b1;
                        i_next = cnt_reg - 1'b1;
                        if (j_reg + 1'b1 >= cnt_reg)
                        begin
                            i_next      = '0;
                            cvalid_next = 1'b1;
                            state_next  = nddi_pkg::S_EM_RD;
                        end
                    end
                    else
                        i_next = i_reg - 1'b1;
                end
                else
                begin
                    div_start  = 1'b1;
                    dneg_next  = dnode[DW] ^ dwork[DW];
                    bst_next   = base_st;
                    state_next = nddi_pkg::S_B_DIV;
                end
            end

            nddi_pkg::S_B_DIV:
            begin
                if (div_done)
                begin
                    work_we    = 1'b1;
                    work_wdata = {(s_div.hit && bst_reg == nddi_pkg::ST_OK) ? nddi_pkg::ST_SAT
                                  : bst_reg, s_div.val};
                    state_next = nddi_pkg::S_B_RD;
                    if (build_next_j)
                    begin
                        j_next = j_reg + 1'b1;
                        i_next = cnt_reg - 1'b1;
                        if (j_reg + 1'b1 >= cnt_reg)
                        begin
                            i_next      = '0;
                            cvalid_next = 1'b1;
                            state_next  = nddi_pkg::S_EM_RD;
                        end
                    end
                    else
                        i_next = i_reg - 1'b1;
                end
            end

            nddi_pkg::S_EM_RD:
            begin
                rd_en      = 1'b1;
                wa0        = i_reg[IW-1:0];
                state_next = nddi_pkg::S_EM_OUT;
            end

            nddi_pkg::S_EM_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next           = 1'b1;
                    out_data_next.value      = w0_reg[DW-1:0];
                    out_data_next.index      = i_reg[nddi_pkg::INDEX_W-1:0];
                    out_data_next.kind       = nddi_pkg::KIND_COEF;
                    out_data_next.status     = w0_reg[DW+1:DW];
                    out_data_next.end_of_run = (i_reg + 1'b1 == cnt_reg);
                    i_next                   = i_reg + 1'b1;
                    state_next = (i_reg + 1'b1 == cnt_reg) ? nddi_pkg::S_IDLE
                                                           : nddi_pkg::S_EM_RD;
                end
            end

            // evaluation: acc = c0, then per k a product update and an accumulate
            nddi_pkg::S_EV_RD0:
            begin
                rd_en      = 1'b1;
                state_next = nddi_pkg::S_EV_INIT;
            end

            nddi_pkg::S_EV_INIT:
            begin
                acc_next   = w0_reg[DW-1:0];
                prod_next  = nddi_pkg::Q_ONE;
                st_next    = nddi_pkg::ST_OK;
                i_next     = CW'(1);
                state_next = (cnt_reg > CW'(1)) ? nddi_pkg::S_EV_RD : nddi_pkg::S_EV_OUT;
            end

            nddi_pkg::S_EV_RD:
            begin
                rd_en      = 1'b1;
                wa0        = i_reg[IW-1:0];
                na0        = IW'(i_reg - 1'b1);
                state_next = nddi_pkg::S_EV_LD;
            end

            nddi_pkg::S_EV_LD:
            begin
                ma_next    = dx_mag;
                mb_next    = prod_mag;
                mneg_next  = dx[DW] ^ prod_reg[DW-1];
                state_next = nddi_pkg::S_EV_M1A;
            end

            nddi_pkg::S_EV_M1A, nddi_pkg::S_EV_M2A:
            begin
                p_next     = nddi_pkg::PROD_W'(pp);
                state_next = (state_reg == nddi_pkg::S_EV_M1A) ? nddi_pkg::S_EV_M1B
                                                               : nddi_pkg::S_EV_M2B;
            end

            nddi_pkg::S_EV_M1B, nddi_pkg::S_EV_M2B:
            begin
                p_next     = p_reg + {pp, {nddi_pkg::HALF_W{1'b0}}};
                state_next = (state_reg == nddi_pkg::S_EV_M1B) ? nddi_pkg::S_EV_P
                                                               : nddi_pkg::S_EV_ACC;
            end

            nddi_pkg::S_EV_P:
            begin
                prod_next = s_mul.val;
                if (s_mul.hit && st_reg == nddi_pkg::ST_OK)
                    st_next = nddi_pkg::ST_SAT;
                ma_next    = s_mul.val[DW-1] ? nddi_pkg::DEN_W'(-s_mul.val)
                                             : nddi_pkg::DEN_W'(s_mul.val);
                mb_next    = w0_mag;
                mneg_next  = s_mul.val[DW-1] ^ w0_reg[DW-1];
                state_next = nddi_pkg::S_EV_M2A;
            end

            nddi_pkg::S_EV_ACC:
            begin
                acc_next = s_sum.val;
                if (s_sum.hit && st_reg == nddi_pkg::ST_OK)
                    st_next = nddi_pkg::ST_SAT;
                i_next     = i_reg + 1'b1;
                state_next = (i_reg + 1'b1 < cnt_reg) ? nddi_pkg::S_EV_RD
                                                      : nddi_pkg::S_EV_OUT;
            end

            nddi_pkg::S_EV_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next           = 1'b1;
                    out_data_next.value      = acc_reg;
                    out_data_next.index      = '0;
                    out_data_next.kind       = nddi_pkg::KIND_EVAL;
                    out_data_next.status     = st_reg;
                    out_data_next.end_of_run = 1'b1;
                    state_next               = nddi_pkg::S_IDLE;
                end
            end

            default:
                state_next = nddi_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= nddi_pkg::S_IDLE;
            cnt_reg       <= '0;
            cvalid_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            cvalid_reg    <= cvalid_next;
            out_valid_reg <= out_valid_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        acc_reg      <= acc_next;
        prod_reg     <= prod_next;
        st_reg       <= st_next;
        bst_reg      <= bst_next;
        dneg_reg     <= dneg_next;
        ma_reg       <= ma_next;
        mb_reg       <= mb_next;
        mneg_reg     <= mneg_next;
        p_reg        <= p_next;
        out_data_reg <= out_data_next;
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(nddi_pkg::MAX_POINTS))
        else $error("node count beyond store depth");
    a_valid_has_nodes: assert property (@(posedge clk) disable iff (!rst_n)
        cvalid_reg |-> cnt_reg != '0)
        else $error("coefficients marked valid with no nodes");
    a_div_from_calc: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> state_reg == nddi_pkg::S_B_CALC)
        else $error("division started outside the build step");
    a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
        work_we |-> state_reg == nddi_pkg::S_IDLE || state_reg == nddi_pkg::S_B_CALC
                 || state_reg == nddi_pkg::S_B_DIV)
        else $error("table write during evaluation or emission");
    a_build_order: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == nddi_pkg::S_B_RD |-> j_reg >= CW'(1) && i_reg >= j_reg && i_reg < cnt_reg)
        else $error("difference table indices out of order");
`endif

endmodule

>>> dv/newton_divided_difference_interp_tb.sv
// Testbench for newton_divided_difference_interp: directed table, full-store run, then random
// load sets and queries, checked against a behavioral predictor. Depends on nddi_pkg, nddi_if.
`timescale 1ns / 1ps

module newton_divided_difference_interp_tb;

    logic clk;
    logic rst_n;

    nddi_in_if  din ();
    nddi_out_if dout ();

    newton_divided_difference_interp i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (din),
        .dout  (dout)
    );

    // clock: 2 ns period
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // interpolator state mirrored by the predictor
    logic signed [31:0] node_x [nddi_pkg::MAX_POINTS];
    logic signed [31:0] diff_tab [nddi_pkg::MAX_POINTS];
    logic signed [31:0] coef_tab [nddi_pkg::MAX_POINTS];
    int unsigned        node_cnt;
    bit                 coefs_ready;

    nddi_pkg::out_item_t expected_q [$];
    int        error_count;
    int        result_count;
    int        coef_results;
    int        eval_results;
    int        idle_cycles;
    bit        sending_done;

    // directed rows; chk set where the expectation is written out
    typedef struct {
        nddi_pkg::in_item_t  item;
        bit                  chk;
        nddi_pkg::out_item_t res;
    } row_t;

    // saturate to 32 bits, raise status to saturated if clipped
    function automatic logic signed [31:0] clip32(input longint v, inout int unsigned st);
        if (v > 64'sd2147483647)
        begin
            if (st < nddi_pkg::ST_SAT) st = nddi_pkg::ST_SAT;
            return 32'sh7fffffff;
        end
        if (v < -64'sd2147483648)
        begin
            if (st < nddi_pkg::ST_SAT) st = nddi_pkg::ST_SAT;
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // Q-format multiply, truncating toward zero
    function automatic longint qmul(input longint a, input longint b);
        logic [63:0] ua, ub, p;
        ua = a < 0 ? -a : a;
        ub = b < 0 ? -b : b;
        p  = (ua * ub) >> nddi_pkg::FRAC_BITS;
        return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
    endfunction

    // Q-format divide, truncating toward zero
    function automatic longint qdiv(input longint n, input longint d);
        logic [63:0] un, ud, q;
        un = n < 0 ? -n : n;
        ud = d < 0 ? -d : d;
        q  = (un << nddi_pkg::FRAC_BITS) / ud;
        return ((n < 0) != (d < 0)) ? -longint'(q) : longint'(q);
    endfunction

    function automatic nddi_pkg::out_item_t mk_res(input logic signed [31:0] v, input int ix,
                                                   input logic k, input int unsigned st,
                                                   input logic e);
        nddi_pkg::out_item_t r;
        r.value      = v;
        r.index      = ix[3:0];
        r.kind       = k;
        r.status     = st[1:0];
        r.end_of_run = e;
        return r;
    endfunction

    // append one expected result
    task automatic queue_result(input nddi_pkg::out_item_t r);
        expected_q.insert(expected_q.size(), r);
    endtask

    // predictor: queue the results one accepted transaction causes
    task automatic predict_interp(input nddi_pkg::in_item_t it);
        int unsigned fl [nddi_pkg::MAX_POINTS];
        int unsigned st;
        longint d, num;
        logic signed [31:0] acc, prod;
        int n;
        if (it.func != nddi_pkg::FUNC_LOAD)
        begin
            if (!coefs_ready || node_cnt == 0)
            begin
                queue_result(mk_res(0, 0, nddi_pkg::KIND_EVAL, nddi_pkg::ST_NRDY, 1'b1));
                return;
            end
            st   = nddi_pkg::ST_OK;
            acc  = coef_tab[0];
            prod = nddi_pkg::Q_ONE;
            for (int k = 1; k < node_cnt; k++)
            begin
                prod = clip32(qmul(longint'(it.x) - longint'(node_x[k-1]), prod), st);
                acc  = clip32(longint'(acc) + qmul(prod, coef_tab[k]), st);
            end
            queue_result(mk_res(acc, 0, nddi_pkg::KIND_EVAL, st, 1'b1));
            return;
        end
        if (coefs_ready)
        begin
            coefs_ready = 1'b0;
            node_cnt    = 0;
        end
        if (node_cnt < nddi_pkg::MAX_POINTS)
        begin
            node_x[node_cnt]   = it.x;
            diff_tab[node_cnt] = it.y;
            node_cnt++;
        end
        if (!it.last)
            return;
        n = node_cnt;
        for (int i = 0; i < n; i++)
            fl[i] = nddi_pkg::ST_OK;
        for (int j = 1; j < n; j++)
            for (int i = n - 1; i >= j; i--)
            begin
                d = longint'(node_x[i]) - longint'(node_x[i-j]);
                if (d == 0)
                begin
                    diff_tab[i] = 0;
                    fl[i]       = nddi_pkg::ST_DUP;
                end
                else
                begin
                    st  = fl[i] > fl[i-1] ? fl[i] : fl[i-1];
                    num = longint'(diff_tab[i]) - longint'(diff_tab[i-1]);
                    diff_tab[i] = clip32(qdiv(num, d), st);
                    fl[i] = st;
                end
            end
        for (int i = 0; i < n; i++)
        begin
            coef_tab[i] = diff_tab[i];
            queue_result(mk_res(diff_tab[i], i, nddi_pkg::KIND_COEF, fl[i], i == n - 1));
        end
        coefs_ready = 1'b1;
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint exp);
        $display("mismatch on result %0d: %s got 0x%0h expected 0x%0h",
                 result_count, what, got, exp);
        error_count++;
    endtask

    // short-biased random gap
    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 40);
        if ($urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, 3);
    endfunction

    // offer one transaction at the falling edge and wait until accepted;
    // a typed expectation, when given, takes the place of the predicted one
    task automatic send_item(input nddi_pkg::in_item_t it, input bit chk = 1'b0,
                             input nddi_pkg::out_item_t res = '0);
        int g;
        din.data  <= it;
        din.valid <= 1'b1;
        do @(posedge clk); while (!din.ready);
        predict_interp(it);
        if (chk)
            expected_q[expected_q.size() - 1] = res;
        @(negedge clk);
        g = gap_len();
        if (g != 0)
        begin
            din.valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
    endtask

    function automatic nddi_pkg::in_item_t mk_item(input logic f, input logic signed [31:0] x,
                                                   input logic signed [31:0] y, input logic l);
        nddi_pkg::in_item_t it;
        it.func = f;
        it.x    = x;
        it.y    = y;
        it.last = l;
        return it;
    endfunction

    // random x: mostly small spread abscissas, sometimes any 32-bit value
    function automatic logic signed [31:0] rnd_x();
        if ($urandom_range(0, 9) == 0)
            return $urandom;
        return $signed($urandom_range(0, 16 * 65536)) - 32'sd524288;
    endfunction

    function automatic logic signed [31:0] rnd_y();
        if ($urandom_range(0, 7) == 0)
            return $urandom;
        return $signed($urandom_range(0, 200 * 65536)) - 32'sd6553600;
    endfunction

    // directed stimulus
    task automatic run_directed();
        row_t tbl [$];
        row_t r;
        // query before any set: not ready
        r.item = mk_item(1'b1, 32'sh7fffffff, 32'sh80000000, 1'b1);
        r.chk  = 1'b1;
        r.res  = mk_res(0, 0, nddi_pkg::KIND_EVAL, nddi_pkg::ST_NRDY, 1'b1);
        tbl.insert(tbl.size(), r);
        // a single node gives c0 = y0
        r.item = mk_item(1'b0, 32'sh80000000, 32'sh7fffffff, 1'b1);
        r.res  = mk_res(32'sh7fffffff, 0, nddi_pkg::KIND_COEF, nddi_pkg::ST_OK, 1'b1);
        tbl.insert(tbl.size(), r);
        // one coefficient: query returns c0
        r.item = mk_item(1'b1, 32'sh12345678, 0, 1'b0);
        r.res  = mk_res(32'sh7fffffff, 0, nddi_pkg::KIND_EVAL, nddi_pkg::ST_OK, 1'b1);
        tbl.insert(tbl.size(), r);
        r.chk = 1'b0;
        // duplicate nodes, extreme values
        r.item = mk_item(1'b0, 32'sh80000000, 32'sh80000000, 1'b0); tbl.insert(tbl.size(), r);
        r.item = mk_item(1'b0, 32'sh80000000, 32'sh7fffffff, 1'b0); tbl.insert(tbl.size(), r);
        r.item = mk_item(1'b0, 32'sh7fffffff, 32'sh80000000, 1'b1); tbl.insert(tbl.size(), r);
        r.item = mk_item(1'b1, 32'sh7fffffff, 0, 1'b0); tbl.insert(tbl.size(), r);
        r.item = mk_item(1'b1, 32'sh80000000, 0, 1'b0); tbl.insert(tbl.size(), r);
        // close nodes with large y difference: saturation
        r.item = mk_item(1'b0, 0, 32'sh80000000, 1'b0); tbl.insert(tbl.size(), r);
        r.item = mk_item(1'b0, 1, 32'sh7fffffff, 1'b1); tbl.insert(tbl.size(), r);
        r.item = mk_item(1'b1, 32'sh00640000, 0, 1'b0); tbl.insert(tbl.size(), r);
        // small well-behaved set then query
        r.item = mk_item(1'b0, 32'sh00000000, 32'sh00010000, 1'b0); tbl.insert(tbl.size(), r);
        r.item = mk_item(1'b0, 32'sh00010000, 32'sh00020000, 1'b0); tbl.insert(tbl.size(), r);
        r.item = mk_item(1'b0, 32'sh00020000, 32'sh00050000, 1'b1); tbl.insert(tbl.size(), r);
        r.item = mk_item(1'b1, 32'sh00018000, 32'shffffffff, 1'b1); tbl.insert(tbl.size(), r);
        foreach (tbl[i])
            send_item(tbl[i].item, tbl[i].chk, tbl[i].res);
    endtask

    // full store: 18 loads, two of them dropped, last one closes the set
    task automatic run_overflow();
        for (int i = 0; i < nddi_pkg::MAX_POINTS + 2; i++)
            send_item(mk_item(1'b0, i * 32'sh00008000, rnd_y(),
                              i == nddi_pkg::MAX_POINTS + 1));
        send_item(mk_item(1'b1, rnd_x(), $urandom, 1'b0));
    endtask

    // stimulus
    initial
    begin
        int n;
        rst_n        = 1'b0;
        din.valid    = 1'b0;
        din.data     = '0;
        dout.ready   = 1'b0;
        node_cnt     = 0;
        coefs_ready  = 1'b0;
        error_count  = 0;
        result_count = 0;
        coef_results = 0;
        eval_results = 0;
        sending_done = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        run_directed();
        run_overflow();
        // random: mostly small sets, each followed by up to three queries, some noise
        for (int s = 0; s < 55; s++)
        begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 5);
            for (int i = 0; i < n; i++)
                send_item(mk_item(1'b0, rnd_x(), rnd_y(), i == n - 1));
            repeat ($urandom_range(0, 3))
                send_item(mk_item(1'b1, rnd_x(), $urandom, $urandom_range(0, 1)));
        end
        din.valid <= 1'b0;
        sending_done = 1'b1;
    end

    // receiver with random stalls; a long hold-off early on fills the block
    initial
    begin
        @(posedge rst_n);
        repeat (440) @(negedge clk);
        forever
        begin
            @(negedge clk);
            dout.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
            begin
                @(negedge clk);
                dout.ready <= 1'b0;
                repeat (gap_len()) @(negedge clk);
            end
        end
    end

    // checker
    always @(posedge clk)
    begin
        nddi_pkg::out_item_t g, e;
        if (dout.valid && dout.ready)
        begin
            g = dout.data;
            if (expected_q.size() == 0)
                report_mismatch("unexpected result value", g.value, 0);
            else
            begin
                e = expected_q.pop_front();
                if (g.value !== e.value) report_mismatch("value", g.value, e.value);
                if (g.index !== e.index) report_mismatch("index", g.index, e.index);
                if (g.kind !== e.kind) report_mismatch("kind", g.kind, e.kind);
                if (g.status !== e.status) report_mismatch("status", g.status, e.status);
                if (g.end_of_run !== e.end_of_run)
                    report_mismatch("end_of_run", g.end_of_run, e.end_of_run);
                if (e.kind == nddi_pkg::KIND_EVAL) eval_results++;
                else coef_results++;
            end
            result_count++;
        end
    end

    // watchdog: cycles with no transaction on either side
    always @(posedge clk)
    begin
        if ((din.valid && din.ready) || (dout.valid && dout.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 40000)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // end of run
    initial
    begin
        idle_cycles = 0;
        wait (sending_done);
        wait (expected_q.size() == 0);
        repeat (200) @(posedge clk);
        $display("covered %0d coefficient and %0d evaluation results", coef_results,
                 eval_results);
        $display("including not ready, duplicate, saturated and full-store cases");
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
